// File: rtl/rot_pkg.sv
// shared types, constants and helpers for the 90 degree frame rotator
// no dependencies; rot_front, rot_queue, rot_back and the top level import this package
`default_nettype none

package rot_pkg;

    localparam int MAX_WIDTH    = 256;
    localparam int MAX_HEIGHT   = 256;
    localparam int MAX_CHANNELS = 4;
    localparam int STORE_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int COUNT_W      = ADDR_W + 1;
    localparam int DIM_W        = 9;
    localparam int CHAN_W       = 3;
    localparam int CFG_DATA_W   = 9;
    localparam int CFG_INDEX_W  = 2;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT  = 2'd1,
        REG_CHANNEL_COUNT = 2'd2
    } reg_index_t;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        CMD_WRITE      = 2'd0,
        CMD_READ_PIXEL = 2'd1,
        CMD_READ_EMPTY = 2'd2
    } cmd_kind_t;

    // one classified beat handed from the front to the back
    typedef struct packed {
        cmd_kind_t         kind;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       data;
        logic [CHAN_W-1:0] chans;
        logic              last;
    } cmd_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        begin
            r = v;
            if (v == '0)
            begin
                r = DIM_W'(1);
            end
            else if (v > hi)
            begin
                r = hi;
            end
            return r;
        end
    endfunction

    function automatic logic [CHAN_W-1:0] clamp_chan(input logic [CHAN_W-1:0] v);
        logic [CHAN_W-1:0] r;
        begin
            r = v;
            if (v == '0)
            begin
                r = CHAN_W'(1);
            end
            else if (v > CHAN_W'(MAX_CHANNELS))
            begin
                r = CHAN_W'(MAX_CHANNELS);
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/rot_in_if.sv
// input channel: op plus the four channel bytes of a written pixel
// no dependencies
`default_nettype none

interface rot_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] chan0_in;
    logic [7:0] chan1_in;
    logic [7:0] chan2_in;
    logic [7:0] chan3_in;

    modport source (output valid, output op, output chan0_in, output chan1_in,
                    output chan2_in, output chan3_in, input ready);
    modport sink   (input valid, input op, input chan0_in, input chan1_in,
                    input chan2_in, input chan3_in, output ready);
endinterface

`default_nettype wire

// File: rtl/rot_out_if.sv
// output channel: one result beat per read
// no dependencies
`default_nettype none

interface rot_out_if;
    logic       valid;
    logic       ready;
    logic       pixel_valid;
    logic [7:0] chan0_out;
    logic [7:0] chan1_out;
    logic [7:0] chan2_out;
    logic [7:0] chan3_out;
    logic       last_pixel;

    modport source (output valid, output pixel_valid, output chan0_out,
                    output chan1_out, output chan2_out, output chan3_out,
                    output last_pixel, input ready);
    modport sink   (input valid, input pixel_valid, input chan0_out,
                    input chan1_out, input chan2_out, input chan3_out,
                    input last_pixel, output ready);
endinterface

`default_nettype wire

// File: rtl/rot_front.sv
// front end: config registers, frame counters and address generation
// depends on rot_pkg and rot_in_if
`default_nettype none

module rot_front
    import rot_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    rot_in_if.sink                      pixel_in,
    input  wire logic                   queue_full,
    output logic                        push,
    output cmd_t                        cmd
);

    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [CHAN_W-1:0]  chans_reg;
    logic [COUNT_W-1:0] write_count_reg, write_count_next;
    logic [DIM_W-1:0]   out_row_reg, out_row_next;
    logic [DIM_W-1:0]   out_col_reg, out_col_next;
    logic               read_done_reg, read_done_next;

    logic [COUNT_W-1:0] total;
    logic               complete;
    logic [DIM_W-1:0]   src_row;
    logic [COUNT_W-1:0] addr_full;
    logic [COUNT_W-1:0] base;
    logic               row_last;
    logic               col_last;
    logic               in_range;

    assign pixel_in.ready = !queue_full;
    assign push           = pixel_in.valid && !queue_full;

    // registers are clamped on the way in
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(MAX_WIDTH);
            height_reg <= DIM_W'(MAX_HEIGHT);
            chans_reg  <= CHAN_W'(3);
        end
        else if (cfg_write_en)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_FRAME_WIDTH:   width_reg  <= clamp_dim(cfg_data, DIM_W'(MAX_WIDTH));
                REG_FRAME_HEIGHT:  height_reg <= clamp_dim(cfg_data, DIM_W'(MAX_HEIGHT));
                REG_CHANNEL_COUNT: chans_reg  <= clamp_chan(cfg_data[CHAN_W-1:0]);
                default:           ;
            endcase
        end
    end

    assign total     = {{(COUNT_W-DIM_W){1'b0}}, width_reg}
                     * {{(COUNT_W-DIM_W){1'b0}}, height_reg};
    assign complete  = write_count_reg >= total;
    assign src_row   = height_reg - DIM_W'(1) - out_col_reg;
    assign addr_full = {{(COUNT_W-DIM_W){1'b0}}, src_row}
                     * {{(COUNT_W-DIM_W){1'b0}}, width_reg}
                     + {{(COUNT_W-DIM_W){1'b0}}, out_row_reg};
    assign row_last  = out_row_reg == width_reg - DIM_W'(1);
    assign col_last  = out_col_reg == height_reg - DIM_W'(1);
    assign in_range  = (out_row_reg < width_reg) && (out_col_reg < height_reg);
    assign base      = complete ? '0 : write_count_reg;

    always_comb
    begin
        write_count_next = write_count_reg;
        out_row_next     = out_row_reg;
        out_col_next     = out_col_reg;
        read_done_next   = read_done_reg;
        cmd.kind         = CMD_READ_EMPTY;
        cmd.addr         = base[ADDR_W-1:0];
        cmd.data         = {pixel_in.chan3_in, pixel_in.chan2_in,
                            pixel_in.chan1_in, pixel_in.chan0_in};
        cmd.chans        = chans_reg;
        cmd.last         = 1'b0;

        if (push)
        begin
            if (op_t'(pixel_in.op) == OP_WRITE)
            begin
                cmd.kind = CMD_WRITE;
                write_count_next = base + COUNT_W'(1);
                if (complete)
                begin
                    out_row_next   = '0;
                    out_col_next   = '0;
                    read_done_next = 1'b0;
                end
            end
            else
            begin
                priority if (!complete || read_done_reg)
                begin
                    cmd.kind = CMD_READ_EMPTY;
                end
                else if (!in_range)
                begin
                    cmd.kind       = CMD_READ_EMPTY;
                    read_done_next = 1'b1;
                end
                else
                begin
                    cmd.kind = CMD_READ_PIXEL;
                    cmd.addr = addr_full[ADDR_W-1:0];
                    cmd.last = row_last && col_last;
                    if (col_last)
                    begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + DIM_W'(1);
                        if (row_last)
                        begin
                            read_done_next = 1'b1;
                        end
                    end
                    else
                    begin
                        out_col_next = out_col_reg + DIM_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_count_reg <= '0;
            out_row_reg     <= '0;
            out_col_reg     <= '0;
            read_done_reg   <= 1'b0;
        end
        else
        begin
            write_count_reg <= write_count_next;
            out_row_reg     <= out_row_next;
            out_col_reg     <= out_col_next;
            read_done_reg   <= read_done_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/rot_queue.sv
// short command queue between front and back
// depends on rot_pkg
`default_nettype none

module rot_queue
    import rot_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output cmd_t      head_cmd,
    output logic      full,
    output logic      empty
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full     = count_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/rot_back.sv
// back end: frame store, read stage and output register
// depends on rot_pkg and rot_out_if
`default_nettype none

module rot_back
    import rot_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cmd_t head_cmd,
    input  wire logic queue_empty,
    output logic      pop,
    rot_out_if.source pixel_out
);

    logic [31:0]       frame_store [STORE_DEPTH];
    logic [31:0]       rd_data_reg;

    logic              s1_valid_reg, s1_valid_next;
    logic              s1_pixel_reg;
    logic [CHAN_W-1:0] s1_chans_reg;
    logic              s1_last_reg;

    logic              out_valid_reg, out_valid_next;
    logic              out_pixel_reg;
    logic [7:0]        out_chan_reg [MAX_CHANNELS];
    logic              out_last_reg;

    logic              out_free;
    logic              s1_free;
    logic              do_write;
    logic              do_read;
    logic              do_fetch;

    assign out_free = !out_valid_reg || pixel_out.ready;
    assign s1_free  = !s1_valid_reg || out_free;
    assign pop      = !queue_empty && s1_free;
    assign do_write = pop && head_cmd.kind == CMD_WRITE;
    assign do_read  = pop && head_cmd.kind != CMD_WRITE;
    assign do_fetch = pop && head_cmd.kind == CMD_READ_PIXEL;

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            frame_store[head_cmd.addr] <= head_cmd.data;
        end
        if (do_fetch)
        begin
            rd_data_reg <= frame_store[head_cmd.addr];
        end
    end

    always_comb
    begin
        s1_valid_next  = s1_free ? do_read : s1_valid_reg;
        out_valid_next = out_free ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (do_read)
        begin
            s1_pixel_reg <= head_cmd.kind == CMD_READ_PIXEL;
            s1_chans_reg <= head_cmd.chans;
            s1_last_reg  <= head_cmd.last;
        end
        if (out_free && s1_valid_reg)
        begin
            out_pixel_reg <= s1_pixel_reg;
            out_last_reg  <= s1_pixel_reg && s1_last_reg;
            for (int k = 0; k < MAX_CHANNELS; k++)
            begin
                // unused channels and empty reads come out as zero
                out_chan_reg[k] <= (s1_pixel_reg && CHAN_W'(k) < s1_chans_reg)
                                 ? rd_data_reg[8*k +: 8] : 8'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign pixel_out.valid       = out_valid_reg;
    assign pixel_out.pixel_valid = out_pixel_reg;
    assign pixel_out.chan0_out   = out_chan_reg[0];
    assign pixel_out.chan1_out   = out_chan_reg[1];
    assign pixel_out.chan2_out   = out_chan_reg[2];
    assign pixel_out.chan3_out   = out_chan_reg[3];
    assign pixel_out.last_pixel  = out_last_reg;

endmodule

`default_nettype wire

// File: rtl/image_rotate_90_clockwise.sv
// top level of the 90 degree clockwise frame rotator
// depends on rot_pkg, rot_in_if, rot_out_if, rot_front, rot_queue, rot_back
`default_nettype none

// channel     dir  beat contents
// pixel_in    in   op, chan0_in..chan3_in (write one source pixel or request one)
// pixel_out   out  pixel_valid, chan0_out..chan3_out, last_pixel (one per read)
// cfg_*       in   cfg_index, cfg_data (frame_width, frame_height, channel_count)
//
// one beat per cycle is taken on pixel_in and given on pixel_out when neither side stalls
// a read beat reaches pixel_out through the queue entry, written at the accepting edge, then
// the frame store read register, then the output register
// reset clears counters and pipeline valids and sets the config registers to their defaults;
// the frame store has no clearing pass and entries are defined once written
// the four-entry queue and the output register let pixel_in run while pixel_out stalls

module image_rotate_90_clockwise
    import rot_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    rot_in_if.sink                      pixel_in,
    rot_out_if.source                   pixel_out
);

    // classified beats from the front
    cmd_t front_cmd;
    logic front_push;
    // head of the queue towards the back
    cmd_t head_cmd;
    logic queue_full;
    logic queue_empty;
    logic back_pop;

    // front: register writes, write count, rotated read position, store address
    rot_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_in     (pixel_in),
        .queue_full   (queue_full),
        .push         (front_push),
        .cmd          (front_cmd)
    );

    // keeps writes and reads in order between the two halves
    rot_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (front_push),
        .push_cmd (front_cmd),
        .pop      (back_pop),
        .head_cmd (head_cmd),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    // back: frame store access and the result register
    rot_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_cmd    (head_cmd),
        .queue_empty (queue_empty),
        .pop         (back_pop),
        .pixel_out   (pixel_out)
    );

endmodule

`default_nettype wire

// File: sim/image_rotate_90_clockwise_test.sv
`timescale 1ns / 1ps

// self-checking testbench for the 90 degree clockwise frame rotator
// depends on rot_pkg, rot_in_if, rot_out_if and image_rotate_90_clockwise

module image_rotate_90_clockwise_test
    import rot_pkg::*;
();

    localparam int RANDOM_ITEMS   = 300;
    localparam int DRAIN_CYCLES   = 8;     // a little over the three-stage read path
    localparam int WATCHDOG_LIMIT = 1000;  // cycles with no beat on either side

    // one result beat as the checker sees it
    typedef struct packed {
        logic            pixel_valid;
        logic [3:0][7:0] chans;
        logic            last_pixel;
    } rotated_pixel_t;

    // how the result side throttles ready
    typedef enum logic [1:0] {
        SINK_OPEN   = 2'd0,
        SINK_COIN   = 2'd1,
        SINK_BLOCKS = 2'd2
    } sink_mode_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    rot_in_if  pixel_in();
    rot_out_if pixel_out();

    image_rotate_90_clockwise DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_in     (pixel_in),
        .pixel_out    (pixel_out)
    );

    // predictor state: a private copy of the frame store, counters and registers
    logic [31:0]       frame_mem [STORE_DEPTH];
    int unsigned       pixels_stored;
    int unsigned       next_row;
    int unsigned       next_col;
    bit                frame_sent;
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [CHAN_W-1:0] chans_reg;

    // rotated pixels still owed by the block, oldest first
    rotated_pixel_t pending_pixels[$];

    int unsigned error_count  = 0;
    int unsigned items_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned burst_left   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned stall_left   = 0;
    int unsigned mode_cycles  = 0;
    sink_mode_t  sink_mode    = SINK_OPEN;

    // 10 ns clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // registers out of range behave as the nearest legal value
    function automatic int unsigned clamp_to(input int unsigned v, input int unsigned hi);
        if (v == 0)
        begin
            return 1;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function automatic int unsigned frame_total();
        return clamp_to(32'(width_reg), MAX_WIDTH) * clamp_to(32'(height_reg), MAX_HEIGHT);
    endfunction

    // apply one accepted input beat; a read queues the pixel it should return
    function automatic void predict_beat(input op_t op, input logic [31:0] bytes);
        int unsigned    w;
        int unsigned    h;
        int unsigned    ch;
        int unsigned    src_addr;
        rotated_pixel_t px;
        w  = clamp_to(32'(width_reg), MAX_WIDTH);
        h  = clamp_to(32'(height_reg), MAX_HEIGHT);
        ch = clamp_to(32'(chans_reg), MAX_CHANNELS);
        px = '0;
        if (op == OP_WRITE)
        begin
            // a write onto a complete frame opens a fresh one
            if (pixels_stored >= w * h)
            begin
                pixels_stored = 0;
                next_row      = 0;
                next_col      = 0;
                frame_sent    = 1'b0;
            end
            if (pixels_stored < STORE_DEPTH)
            begin
                frame_mem[ADDR_W'(pixels_stored)] = bytes;
            end
            pixels_stored++;
            return;
        end
        // incomplete frame or frame already sent: all-zero beat
        if (pixels_stored >= w * h && !frame_sent)
        begin
            if (next_row >= w || next_col >= h)
            begin
                // read position fell outside a shrunk frame
                frame_sent = 1'b1;
            end
            else
            begin
                // output row r, column c comes from source row h-1-c, column r
                src_addr       = (h - 1 - next_col) * w + next_row;
                px.pixel_valid = 1'b1;
                for (int k = 0; k < 4; k++)
                begin
                    if (k < ch)
                    begin
                        px.chans[k] = frame_mem[ADDR_W'(src_addr)][8*k +: 8];
                    end
                end
                px.last_pixel = (next_row + 1 >= w) && (next_col + 1 >= h);
                if (next_col + 1 >= h)
                begin
                    next_col = 0;
                    next_row++;
                    if (next_row >= w)
                    begin
                        frame_sent = 1'b1;
                    end
                end
                else
                begin
                    next_col++;
                end
            end
        end
        pending_pixels.push_back(px);
    endfunction

    // ------------------------------------------------------------------
    // pixel_in driver: bursts of beats with random gaps between them
    // ------------------------------------------------------------------

    task automatic pause_sender();
        pixel_in.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        // now and then a long unbroken burst
        if ($urandom_range(0, 3) == 0)
        begin
            burst_left = $urandom_range(60, 200);
        end
        else
        begin
            burst_left = $urandom_range(1, 24);
        end
    endtask

    // valid is left high on return so back-to-back beats need no second assignment
    task automatic send_beat(input op_t op, input logic [31:0] bytes);
        if (burst_left == 0)
        begin
            pause_sender();
        end
        pixel_in.valid    <= 1'b1;
        pixel_in.op       <= op;
        pixel_in.chan0_in <= bytes[7:0];
        pixel_in.chan1_in <= bytes[15:8];
        pixel_in.chan2_in <= bytes[23:16];
        pixel_in.chan3_in <= bytes[31:24];
        @(posedge clk);
        while (!pixel_in.ready)
        begin
            @(posedge clk);
        end
        predict_beat(op, bytes);
        burst_left--;
        items_sent++;
    endtask

    // drop valid, let every owed result out, then cover writes still in flight
    task automatic wait_idle();
        pixel_in.valid <= 1'b0;
        while (pending_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // register writes, only ever made with the block idle
    // ------------------------------------------------------------------

    task automatic set_register(input reg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        unique case (idx)
            REG_FRAME_WIDTH:   width_reg  = value;
            REG_FRAME_HEIGHT:  height_reg = value;
            REG_CHANNEL_COUNT: chans_reg  = value[CHAN_W-1:0];
            default: ;
        endcase
        // spare cycle so the enable never drops and rises in one step
        @(posedge clk);
    endtask

    task automatic program_frame(input logic [CFG_DATA_W-1:0] w,
                                 input logic [CFG_DATA_W-1:0] h,
                                 input logic [CFG_DATA_W-1:0] ch);
        wait_idle();
        set_register(REG_FRAME_WIDTH, w);
        set_register(REG_FRAME_HEIGHT, h);
        set_register(REG_CHANNEL_COUNT, ch);
    endtask

    // fill up a half-loaded frame so the next write begins a clean one
    task automatic close_open_frame();
        if (pixels_stored != 0)
        begin
            while (pixels_stored < frame_total())
            begin
                send_beat(OP_WRITE, $urandom());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("ERROR: result beat %0d at %0t ns: %s", results_seen, $time, msg);
        error_count++;
    endtask

    always @(posedge clk)
    begin : result_checker
        rotated_pixel_t got;
        rotated_pixel_t want;
        if (rst_n && pixel_out.valid && pixel_out.ready)
        begin
            got = {pixel_out.pixel_valid, pixel_out.chan3_out, pixel_out.chan2_out,
                   pixel_out.chan1_out, pixel_out.chan0_out, pixel_out.last_pixel};
            if (pending_pixels.size() == 0)
            begin
                report_mismatch("result beat with nothing expected");
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (got.pixel_valid !== want.pixel_valid)
                begin
                    report_mismatch($sformatf("pixel_valid %b, expected %b",
                                              got.pixel_valid, want.pixel_valid));
                end
                for (int k = 0; k < 4; k++)
                begin
                    if (got.chans[k] !== want.chans[k])
                    begin
                        report_mismatch($sformatf("chan%0d_out %h, expected %h",
                                                  k, got.chans[k], want.chans[k]));
                    end
                end
                if (got.last_pixel !== want.last_pixel)
                begin
                    report_mismatch($sformatf("last_pixel %b, expected %b",
                                              got.last_pixel, want.last_pixel));
                end
            end
            results_seen++;
        end
    end

    // pixel_out ready: open stretches, coin-flip stretches and stretches with long blocks
    always @(posedge clk)
    begin : sink_pattern
        if (rst_n !== 1'b1)
        begin
            pixel_out.ready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            pixel_out.ready <= 1'b0;
        end
        else
        begin
            if (mode_cycles == 0)
            begin
                sink_mode   = sink_mode_t'($urandom_range(0, 2));
                mode_cycles = $urandom_range(50, 300);
            end
            else
            begin
                mode_cycles--;
            end
            unique case (sink_mode)
                SINK_OPEN:
                    pixel_out.ready <= 1'b1;
                SINK_COIN:
                    pixel_out.ready <= 1'($urandom_range(0, 1));
                default:
                begin
                    if ($urandom_range(0, 19) == 0)
                    begin
                        stall_left      = $urandom_range(4, 24);
                        pixel_out.ready <= 1'b0;
                    end
                    else
                    begin
                        pixel_out.ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // a stretch with no beat on either side means the block has hung
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (pixel_in.valid && pixel_in.ready) ||
            (pixel_out.valid && pixel_out.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // nothing loaded after reset, so reads come back empty
    task automatic test_reset_state();
        send_beat(OP_READ, 32'h0000_0000);
        send_beat(OP_READ, $urandom());
    endtask

    // 3x2 frame, all four channels, extreme bytes; early read, full readout,
    // read past the end, then a write that opens the next frame
    task automatic test_small_frame();
        program_frame(9'd3, 9'd2, 9'd4);
        close_open_frame();
        send_beat(OP_WRITE, 32'h0000_0000);
        send_beat(OP_WRITE, 32'hFFFF_FFFF);
        send_beat(OP_WRITE, 32'h55AA_55AA);
        send_beat(OP_READ, 32'h0000_0000);
        send_beat(OP_WRITE, 32'hAA55_AA55);
        send_beat(OP_WRITE, $urandom());
        send_beat(OP_WRITE, 32'h8040_2010);
        repeat (7) send_beat(OP_READ, $urandom());
        send_beat(OP_WRITE, $urandom());
        send_beat(OP_READ, $urandom());
    endtask

    // zero in every register acts as one; channel counts above four act as four
    task automatic test_register_clamping();
        program_frame(9'd0, 9'd0, 9'd0);
        send_beat(OP_WRITE, 32'hDEAD_BEEF);
        send_beat(OP_READ, $urandom());
        send_beat(OP_READ, $urandom());
        program_frame(9'd0, 9'd0, 9'd7);
        send_beat(OP_WRITE, $urandom());
        send_beat(OP_READ, $urandom());
    endtask

    // frame shrinks under the read position: empty beat and readout ends
    task automatic test_shrink_mid_frame();
        program_frame(9'd2, 9'd2, 9'd2);
        close_open_frame();
        repeat (4) send_beat(OP_WRITE, $urandom());
        send_beat(OP_READ, $urandom());
        wait_idle();
        set_register(REG_FRAME_HEIGHT, 9'd1);
        send_beat(OP_READ, $urandom());
        send_beat(OP_READ, $urandom());
    endtask

    // mostly clean write-then-read frames of small sizes; the rest random op
    // mixes and frames abandoned half loaded, with registers changed between
    task automatic test_random_frames();
        int unsigned first_item;
        int unsigned total;
        int unsigned shape;
        first_item = items_sent;
        while (items_sent - first_item < RANDOM_ITEMS)
        begin
            // keep the settings for about a third of frames so frames run back to back
            if ($urandom_range(0, 2) != 0)
            begin
                if ($urandom_range(0, 24) == 0)
                begin
                    program_frame(CFG_DATA_W'($urandom_range(0, 511)),
                                  CFG_DATA_W'($urandom_range(0, 1)),
                                  CFG_DATA_W'($urandom_range(0, 511)));
                end
                else
                begin
                    program_frame(CFG_DATA_W'($urandom_range(0, 9)),
                                  CFG_DATA_W'($urandom_range(0, 9)),
                                  CFG_DATA_W'($urandom_range(0, 7)));
                end
            end
            total = frame_total();
            shape = $urandom_range(0, 9);
            if (shape < 8)
            begin
                repeat (total) send_beat(OP_WRITE, $urandom());
                repeat (total + $urandom_range(0, 2)) send_beat(OP_READ, $urandom());
            end
            else if (shape == 8)
            begin
                repeat ($urandom_range(1, 2 * total + 2))
                    send_beat(op_t'($urandom_range(0, 1)), $urandom());
            end
            else
            begin
                repeat ($urandom_range(1, total)) send_beat(OP_WRITE, $urandom());
                repeat ($urandom_range(0, total)) send_beat(OP_READ, $urandom());
            end
        end
    endtask

    // widest and tallest frames, one row or one column so they stay short;
    // only the first few rotated pixels are read back
    task automatic test_largest_frames();
        program_frame(9'h100, 9'd1, 9'd5);
        close_open_frame();
        repeat (MAX_WIDTH) send_beat(OP_WRITE, $urandom());
        repeat (3) send_beat(OP_READ, $urandom());
        program_frame(9'd1, 9'h1FF, 9'h1FF);
        close_open_frame();
        repeat (MAX_HEIGHT) send_beat(OP_WRITE, $urandom());
        repeat (3) send_beat(OP_READ, $urandom());
    endtask

    initial
    begin : test_sequence
        // every input known from time zero, reset held low
        rst_n              <= 1'b0;
        cfg_write_en       <= 1'b0;
        cfg_index          <= REG_FRAME_WIDTH;
        cfg_data           <= '0;
        pixel_in.valid     <= 1'b0;
        pixel_in.op        <= OP_WRITE;
        pixel_in.chan0_in  <= 8'h00;
        pixel_in.chan1_in  <= 8'h00;
        pixel_in.chan2_in  <= 8'h00;
        pixel_in.chan3_in  <= 8'h00;

        // predictor at its reset values
        pixels_stored = 0;
        next_row      = 0;
        next_col      = 0;
        frame_sent    = 1'b0;
        width_reg     = DIM_W'(MAX_WIDTH);
        height_reg    = DIM_W'(MAX_HEIGHT);
        chans_reg     = CHAN_W'(3);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_small_frame();
        test_register_clamping();
        test_shrink_mid_frame();
        test_random_frames();
        test_largest_frames();

        // all owed results in, then a settle window for stray beats
        wait_idle();

        if (error_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
